### rtl/teas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teas_pkg
// Shared types and codes for the triangle edge adjacency search.
// ----------------------------------------------------------------------------
package teas_pkg;

	localparam int VERT_W = 16;
	localparam int TRI_W  = 10;
	localparam int CNT_W  = 11;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_FOUND = 2'd0;
	localparam logic [1:0] STATUS_NONE  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// Three vertex indices of one triangle, corner a in the top slot
	typedef logic [2:0][VERT_W-1:0] corners_t;

	typedef struct packed {
		logic              cmd;
		logic [TRI_W-1:0]  triangle;
		logic [VERT_W-1:0] corner_a;
		logic [VERT_W-1:0] corner_b;
		logic [VERT_W-1:0] corner_c;
	} teas_in_t;

	typedef struct packed {
		logic [TRI_W-1:0]  neighbour_triangle;
		logic [VERT_W-1:0] shared_first;
		logic [VERT_W-1:0] shared_second;
		logic [1:0]        status;
		logic              last;
		logic              truncated;
	} teas_out_t;

	// Compare stage result toward the control
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [VERT_W-1:0] shared_first;
		logic [VERT_W-1:0] shared_second;
	} teas_match_t;

	// One buffered neighbour
	typedef struct packed {
		logic [TRI_W-1:0]  triangle;
		logic [VERT_W-1:0] shared_first;
		logic [VERT_W-1:0] shared_second;
	} teas_nb_t;

endpackage

### rtl/teas_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teas_match
// Registered compare of the query corners against one scanned entry.
// ----------------------------------------------------------------------------
module teas_match import teas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  corners_t    query,
	input  corners_t    entry,
	output teas_match_t match
);

	logic [2:0] hit;
	logic       two;
	logic [VERT_W-1:0] first_v;
	logic [VERT_W-1:0] second_v;

	logic              valid_s2;
	logic              hit_s2;
	logic [VERT_W-1:0] first_s2;
	logic [VERT_W-1:0] second_s2;

	// Per query corner: does it occur anywhere in the entry
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			hit[j] = (query[j] == entry[0]) || (query[j] == entry[1]) ||
				(query[j] == entry[2]);
		end
	end

	// Exactly two hits; pick the two corners in query order
	// Slot 2 holds corner a, slot 0 corner c
	assign two      = ($countones(hit) == 2);
	assign first_v  = hit[2] ? query[2] : query[1];
	assign second_v = hit[0] ? query[0] : query[1];

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid;
		end
	end

	// Stage data
	always_ff @(posedge clk) begin
		hit_s2    <= two;
		first_s2  <= first_v;
		second_s2 <= second_v;
	end

	assign match = '{valid: valid_s2, hit: hit_s2, shared_first: first_s2,
		shared_second: second_s2};

endmodule

### rtl/triangle_edge_adjacency_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_search
// Scans the triangle table for entries sharing exactly one edge with a query.
//
//  channel   dir  signals                       transfer when
//  cmd       in   cmd_valid/cmd_ready/cmd_data  cmd_valid && cmd_ready
//  res       out  res_valid/res_ready/res_data  res_valid && res_ready
//  cfg       in   cfg_we/cfg_wdata              cfg_we
//
// A load leaves cmd_ready high. After a query transfer cmd_ready stays low
// while the block fetches its own entry, scans each entry up to the count
// register (capped at MAX_TRIANGLES), drains the compare pipeline, then
// reads and sends each buffered neighbour, or sends a status-only result.
// An out of range query keeps it low only for its status result. Result
// stalls extend the emit and status phases only. No clearing pass after reset.
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_search import teas_pkg::*; #(
	parameter int MAX_TRIANGLES  = 1024,
	parameter int MAX_NEIGHBOURS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  teas_in_t         cmd_data,
	output logic             res_valid,
	input  logic             res_ready,
	output teas_out_t        res_data,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CW = $clog2(MAX_TRIANGLES + 1);
	localparam int BW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int NW = $clog2(MAX_NEIGHBOURS + 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_QRD     = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_DRAIN   = 7'b0001000,
		ST_EMIT_RD = 7'b0010000,
		ST_EMIT_WR = 7'b0100000,
		ST_STATUS  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cfg_q;
	logic [CW-1:0]    count_eff;
	logic [CW-1:0]    i_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    k_q;
	logic             trunc_q;
	logic [1:0]       status_q;
	corners_t         query_q;

	corners_t         table_mem [MAX_TRIANGLES];
	corners_t         ent_s1;
	logic             rv_s1;
	logic [TW-1:0]    idx_s1;
	logic [TW-1:0]    idx_s2;
	teas_match_t      m_s2;

	teas_nb_t         nb_mem [MAX_NEIGHBOURS];
	teas_nb_t         nb_rd_q;

	logic             res_valid_q;
	teas_out_t        res_q;

	logic             cmd_xfer;
	logic             is_query;
	logic             load_ok;
	logic             range_err;
	logic [TW-1:0]    tri_addr;
	logic             mem_we;
	logic             mem_re;
	logic [TW-1:0]    mem_ra;
	logic             scan_last;
	logic             nb_we;
	logic             emit_last;
	logic             res_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Count capped at the table size
	assign count_eff = (32'(cfg_q) > MAX_TRIANGLES) ? CW'(MAX_TRIANGLES) : CW'(cfg_q);

	// Command decode
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign is_query  = (cmd_data.cmd == CMD_QUERY);
	assign tri_addr  = TW'(cmd_data.triangle);
	assign load_ok   = (32'(cmd_data.triangle) < MAX_TRIANGLES);
	assign range_err = (32'(cmd_data.triangle) >= 32'(count_eff));

	// Table port: write on load, read for query fetch and scan
	assign mem_we    = cmd_xfer && !is_query && load_ok;
	assign mem_re    = (cmd_xfer && is_query && !range_err) || (state_q == ST_SCAN);
	assign mem_ra    = (state_q == ST_SCAN) ? i_q[TW-1:0] : tri_addr;
	assign scan_last = (({1'b0, i_q} + 1'b1) == {1'b0, count_eff});

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[tri_addr] <= {cmd_data.corner_a, cmd_data.corner_b, cmd_data.corner_c};
		end
		if (mem_re) begin
			ent_s1 <= table_mem[mem_ra];
		end
	end

	// Scan pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= i_q[TW-1:0];
		idx_s2 <= idx_s1;
	end

	teas_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (rv_s1),
		.query  (query_q),
		.entry  (ent_s1),
		.match  (m_s2)
	);

	// Neighbour buffer
	assign nb_we = m_s2.valid && m_s2.hit && (32'(n_q) < MAX_NEIGHBOURS);

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[n_q[BW-1:0]] <= '{triangle:      TRI_W'(idx_s2),
				shared_first:  m_s2.shared_first,
				shared_second: m_s2.shared_second};
		end
		if (state_q == ST_EMIT_RD) begin
			nb_rd_q <= nb_mem[k_q[BW-1:0]];
		end
	end

	assign emit_last = (({1'b0, k_q} + 1'b1) == {1'b0, n_q});
	assign res_free  = !res_valid_q || res_ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			n_q      <= '0;
			k_q      <= '0;
			trunc_q  <= 1'b0;
			status_q <= STATUS_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer && is_query) begin
						i_q     <= '0;
						n_q     <= '0;
						trunc_q <= 1'b0;
						if (range_err) begin
							status_q <= STATUS_RANGE;
							state_q  <= ST_STATUS;
						end else begin
							state_q <= ST_QRD;
						end
					end
				end
				ST_QRD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					i_q <= i_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rv_s1 && !m_s2.valid) begin
						k_q <= '0;
						if (n_q == '0) begin
							status_q <= STATUS_NONE;
							state_q  <= ST_STATUS;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (res_free) begin
						k_q     <= k_q + 1'b1;
						state_q <= emit_last ? ST_IDLE : ST_EMIT_RD;
					end
				end
				ST_STATUS: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Neighbour count and overflow
			if (m_s2.valid && m_s2.hit) begin
				if (nb_we) begin
					n_q <= n_q + 1'b1;
				end else begin
					trunc_q <= 1'b1;
				end
			end
		end
	end

	// Query corners captured from the fetch
	always_ff @(posedge clk) begin
		if (state_q == ST_QRD) begin
			query_q <= ent_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT_WR || state_q == ST_STATUS) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_WR && res_free) begin
			res_q.neighbour_triangle <= nb_rd_q.triangle;
			res_q.shared_first       <= nb_rd_q.shared_first;
			res_q.shared_second      <= nb_rd_q.shared_second;
			res_q.status             <= STATUS_FOUND;
			res_q.last               <= emit_last;
			res_q.truncated          <= trunc_q;
		end else if (state_q == ST_STATUS && res_free) begin
			res_q.neighbour_triangle <= '0;
			res_q.shared_first       <= '0;
			res_q.shared_second      <= '0;
			res_q.status             <= status_q;
			res_q.last               <= 1'b1;
			res_q.truncated          <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= MAX_NEIGHBOURS)
		else $error("neighbour count above limit");

	a_trunc_full: assert property (@(posedge clk) disable iff (!arst_n)
		trunc_q |-> (32'(n_q) == MAX_NEIGHBOURS))
		else $error("truncated with free buffer slots");

	a_s2_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		m_s2.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("compare result outside scan");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> (n_q != '0 && k_q < n_q))
		else $error("emit index beyond buffered neighbours");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (i_q < count_eff))
		else $error("scan index beyond count");

endmodule
